// ===== rtl/core/hgl_pkg.sv =====
package hgl_pkg;

  // cube coordinate width, wide enough for every line on a 32 x 32 grid
  localparam int CUBE_W = 8;
  // hex distance width
  localparam int LEN_W = 6;
  // rounding remainder width, holds 0 .. 4n-1 and -2n during an update
  localparam int REM_W = 9;
  // scaled rounding error width
  localparam int ERR_W = 11;
  // jobs held between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [CUBE_W-1:0] cube_t;

  // one classified request: start cube, cube delta and hex distance
  typedef struct packed {
    cube_t            x;
    cube_t            y;
    cube_t            z;
    cube_t            dx;
    cube_t            dy;
    cube_t            dz;
    logic [LEN_W-1:0] len;
  } hgl_job_t;

  // running quotient and remainder of one rounded component
  typedef struct packed {
    cube_t                   quo;
    logic signed [REM_W-1:0] rem;
  } hgl_acc_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } walk_state_e;

endpackage

// ===== rtl/core/hgl_front.sv =====
module hgl_front #(
  parameter int COORD_BITS = 5
) (
  input  logic [COORD_BITS-1:0] start_col_i,
  input  logic [COORD_BITS-1:0] start_row_i,
  input  logic [COORD_BITS-1:0] end_col_i,
  input  logic [COORD_BITS-1:0] end_row_i,
  output hgl_pkg::hgl_job_t     job_o
);
  import hgl_pkg::*;

  localparam int PAD_W = CUBE_W - COORD_BITS;

  function automatic logic [CUBE_W-1:0] mag(cube_t v);
    return v[CUBE_W-1] ? CUBE_W'(-v) : CUBE_W'(v);
  endfunction

  cube_t x1, y1, z1, x2, y2, z2;
  cube_t dx, dy, dz;
  logic [CUBE_W+1:0] dist_sum;

  // odd-q offset to cube: x = col, z = row - floor(col/2), y = -x - z
  always_comb begin
    x1 = $signed({{PAD_W{1'b0}}, start_col_i});
    z1 = $signed({{PAD_W{1'b0}}, start_row_i}) -
         $signed({{(PAD_W + 1){1'b0}}, start_col_i[COORD_BITS-1:1]});
    y1 = -(x1 + z1);
    x2 = $signed({{PAD_W{1'b0}}, end_col_i});
    z2 = $signed({{PAD_W{1'b0}}, end_row_i}) -
         $signed({{(PAD_W + 1){1'b0}}, end_col_i[COORD_BITS-1:1]});
    y2 = -(x2 + z2);
  end

  // deltas and hex distance (|dx| + |dy| + |dz|) / 2
  always_comb begin
    dx = x2 - x1;
    dy = y2 - y1;
    dz = z2 - z1;
    dist_sum = {2'b00, mag(dx)} + {2'b00, mag(dy)} + {2'b00, mag(dz)};
  end

  assign job_o = '{x: x1, y: y1, z: z1, dx: dx, dy: dy, dz: dz,
                   len: dist_sum[LEN_W:1]};

endmodule

// ===== rtl/core/hgl_queue.sv =====
module hgl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  hgl_pkg::hgl_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output hgl_pkg::hgl_job_t pop_data_o
);
  import hgl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  hgl_job_t            entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                push, pop;

  assign push_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("queue count did not follow a lone pop");

endmodule

// ===== rtl/core/hgl_back.sv =====
module hgl_back #(
  parameter int COORD_BITS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  hgl_pkg::hgl_job_t     pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] cell_col_o,
  output logic [COORD_BITS-1:0] cell_row_o,
  output logic                  last_o
);
  import hgl_pkg::*;

  // one step of floor((num + inc*i) / two_n) kept as quotient and remainder
  function automatic hgl_acc_t acc_step(hgl_acc_t a, logic signed [REM_W-1:0] inc,
                                        logic signed [REM_W-1:0] two_n);
    logic signed [REM_W-1:0] t;
    hgl_acc_t                r;
    t = a.rem + inc;
    r = '{quo: a.quo, rem: t};
    if (t >= two_n) begin
      r.rem = t - two_n;
      r.quo = a.quo + cube_t'(1);
    end else if (t < 0) begin
      r.rem = t + two_n;
      r.quo = a.quo - cube_t'(1);
    end
    return r;
  endfunction

  function automatic logic [ERR_W-1:0] mag(logic signed [ERR_W-1:0] v);
    return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
  endfunction

  function automatic logic signed [ERR_W-1:0] widen(logic signed [REM_W-1:0] v);
    return $signed({{(ERR_W - REM_W){v[REM_W-1]}}, v});
  endfunction

  walk_state_e             state_q, state_d;
  hgl_job_t                job_q;
  logic [LEN_W-1:0]        step_q;
  hgl_acc_t                acc_x_q, acc_y_q, acc_z_q;
  logic                    out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]   col_q, row_q;
  logic                    last_q;

  logic                    advance, last_cell;
  logic signed [REM_W-1:0] n_s, two_n, init_n;
  logic signed [REM_W-1:0] inc_x, inc_y, inc_z;
  logic signed [ERR_W-1:0] ex_raw, ey_raw, ez_raw;
  logic [ERR_W-1:0]        ex, ey, ez;
  cube_t                   cx, cy, cz, fx, fz, row_full;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      WALK_IDLE: if (pop_valid_i) state_d = WALK_RUN;
      WALK_RUN:  if (advance && last_cell) state_d = WALK_IDLE;
      default:   state_d = WALK_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    pop_ready_o = state_q == WALK_IDLE;
    advance     = (state_q == WALK_RUN) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign last_cell = step_q == job_q.len;
  assign n_s       = $signed({{(REM_W - LEN_W){1'b0}}, job_q.len});
  assign two_n     = $signed({{(REM_W - LEN_W - 1){1'b0}}, job_q.len, 1'b0});
  assign init_n    = $signed({{(REM_W - LEN_W){1'b0}}, pop_data_i.len});
  assign inc_x     = $signed({job_q.dx, 1'b0});
  assign inc_y     = $signed({job_q.dy, 1'b0});
  assign inc_z     = -$signed({job_q.dz, 1'b0});

  // rounded components and their errors scaled by 8n, with the tie nudge
  always_comb begin
    cx = job_q.x + acc_x_q.quo;
    cy = job_q.y + acc_y_q.quo;
    cz = job_q.z - acc_z_q.quo;
    ex_raw = (widen(n_s - acc_x_q.rem) <<< 2) - ERR_W'(1);
    ey_raw = (widen(n_s - acc_y_q.rem) <<< 2) - ERR_W'(1);
    ez_raw = (widen(acc_z_q.rem - n_s) <<< 2) + ERR_W'(2);
    ex = mag(ex_raw);
    ey = mag(ey_raw);
    ez = mag(ez_raw);
  end

  // recompute the component with the largest error, then back to odd-q
  always_comb begin
    fx = cx;
    fz = cz;
    if (ex > ey && ex > ez) begin
      fx = -(cy + cz);
    end else if (ey > ez) begin
      fx = cx;
    end else begin
      fz = -(cx + cy);
    end
    row_full = fz + (fx >>> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WALK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_z_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (pop_valid_i && pop_ready_o) begin
        step_q  <= '0;
        acc_x_q <= '{quo: '0, rem: init_n};
        acc_y_q <= '{quo: '0, rem: init_n};
        acc_z_q <= '{quo: '0, rem: init_n};
      end else if (advance && !last_cell) begin
        step_q  <= step_q + LEN_W'(1);
        acc_x_q <= acc_step(acc_x_q, inc_x, two_n);
        acc_y_q <= acc_step(acc_y_q, inc_y, two_n);
        acc_z_q <= acc_step(acc_z_q, inc_z, two_n);
      end
    end
  end

  // job and output beat registers
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      job_q <= pop_data_i;
    end
    if (advance) begin
      col_q  <= fx[COORD_BITS-1:0];
      row_q  <= row_full[COORD_BITS-1:0];
      last_q <= last_cell;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_col_o  = col_q;
  assign cell_row_o  = row_q;
  assign last_o      = last_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WALK_RUN |-> step_q <= job_q.len)
    else $error("step counter passed line length");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == WALK_RUN |-> acc_x_q.rem >= 0 &&
      (acc_x_q.rem < two_n || job_q.len == '0))
    else $error("x remainder out of range");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_cell |=> state_q == WALK_IDLE && out_valid_q && last_o)
    else $error("final cell not flagged or walker still running");

endmodule

// ===== rtl/core/hex_grid_line_walker.sv =====
// hex line walker for odd-q offset grids
//
// input channel (in_valid_i / in_ready_o) takes one request beat: start and
// end cell as column and row. output channel (out_valid_o / out_ready_i)
// gives the n+1 cells of the line from start to end, one beat per cell, with
// last_o set on the end cell; n is the hex distance, a single cell when the
// two match.
// the front converts a request to cube coordinates and distance in the same
// cycle it is accepted and drops it into a two-entry job queue, so up to two
// requests are taken while the walker is still busy.
// the walker loads a job while idle, then gives one cell per cycle from
// running quotient/remainder accumulators unless the receiver stalls;
// a request passes the queue, job and output registers before its cells.
// when the receiver stalls, the held cell stays on the outputs, the walker
// pauses and the queue keeps filling until full, then in_ready_o drops.
// reset empties the queue and the output register; no request is kept.
module hex_grid_line_walker #(
  parameter int COORD_BITS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] start_col_i,
  input  logic [COORD_BITS-1:0] start_row_i,
  input  logic [COORD_BITS-1:0] end_col_i,
  input  logic [COORD_BITS-1:0] end_row_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] cell_col_o,
  output logic [COORD_BITS-1:0] cell_row_o,
  output logic                  last_o
);
  import hgl_pkg::*;

  hgl_job_t front_job, queue_job;
  logic     queue_valid, back_ready;

  // request classification
  hgl_front #(.COORD_BITS(COORD_BITS)) u_front (
    .start_col_i (start_col_i),
    .start_row_i (start_row_i),
    .end_col_i   (end_col_i),
    .end_row_i   (end_row_i),
    .job_o       (front_job)
  );

  // job queue between front and walker
  hgl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_job),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_job)
  );

  // line walker
  hgl_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (queue_valid),
    .pop_ready_o (back_ready),
    .pop_data_i  (queue_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_col_o  (cell_col_o),
    .cell_row_o  (cell_row_o),
    .last_o      (last_o)
  );

endmodule

// ===== test/hex_grid_line_walker_tb.sv =====
`timescale 1ns / 1ps

module hex_grid_line_walker_tb;

  localparam int COORD_BITS   = 5;
  localparam int RANDOM_LINES = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  // worst case: every line 48 cells, each cell waiting out the longest stall
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   last;
  } cell_t;

  // predicts the cells of each accepted line and checks them in order
  class line_board;
    cell_t cells_due[$];
    int    fails = 0;

    function int floor_quot(int a, int b);
      int q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    // cube lerp with exact rationals over the hex distance
    function void add_line(coord_t sc, coord_t sr, coord_t ec, coord_t er);
      int    x1, y1, z1, x2, y2, z2, dx, dy, dz, n;
      int    px, py, pz, rx, ry, rz, ex, ey, ez;
      cell_t pt;
      x1 = int'(sc);
      z1 = int'(sr) - int'(sc) / 2;
      y1 = -(x1 + z1);
      x2 = int'(ec);
      z2 = int'(er) - int'(ec) / 2;
      y2 = -(x2 + z2);
      dx = x2 - x1;
      dy = y2 - y1;
      dz = z2 - z1;
      n  = (mag(dx) + mag(dy) + mag(dz)) / 2;
      // same cell: emitted once
      if (n == 0) begin
        pt.col  = sc;
        pt.row  = sr;
        pt.last = 1'b1;
        cells_due.push_back(pt);
        return;
      end
      for (int i = 0; i <= n; i++) begin
        px = x1 * n + dx * i;
        py = y1 * n + dy * i;
        pz = z1 * n + dz * i;
        // x and y round halves up, z rounds halves down
        rx = floor_quot(2 * px + n, 2 * n);
        ry = floor_quot(2 * py + n, 2 * n);
        rz = -floor_quot(n - 2 * pz, 2 * n);
        // scaled errors with the tie nudge folded in
        ex = mag(8 * (rx * n - px) - 1);
        ey = mag(8 * (ry * n - py) - 1);
        ez = mag(8 * (rz * n - pz) + 2);
        if (ex > ey && ex > ez) rx = -(ry + rz);
        else if (ey > ez) ry = -(rx + rz);
        else rz = -(rx + ry);
        pt.col  = coord_t'(rx);
        pt.row  = coord_t'(rz + floor_quot(rx, 2));
        pt.last = (i == n);
        cells_due.push_back(pt);
      end
    endfunction

    function void check_cell(coord_t col, coord_t row, logic last);
      cell_t due;
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell, expected none, got col %0d row %0d last %0b",
                 $time, col, row, last);
        fails++;
        return;
      end
      due = cells_due.pop_front();
      if (col !== due.col) begin
        $display("%0t: cell_col mismatch, expected %0d, got %0d", $time, due.col, col);
        fails++;
      end
      if (row !== due.row) begin
        $display("%0t: cell_row mismatch, expected %0d, got %0d", $time, due.row, row);
        fails++;
      end
      if (last !== due.last) begin
        $display("%0t: last mismatch, expected %0b, got %0b", $time, due.last, last);
        fails++;
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  coord_t start_col_i = '0;
  coord_t start_row_i = '0;
  coord_t end_col_i   = '0;
  coord_t end_row_i   = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  coord_t cell_col_o;
  coord_t cell_row_o;
  logic   last_o;

  line_board board = new();
  int        lines_sent  = 0;
  int        cycle_count = 0;
  logic      hold_off    = 1'b0;

  hex_grid_line_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .start_col_i(start_col_i),
    .start_row_i(start_row_i),
    .end_col_i  (end_col_i),
    .end_row_i  (end_row_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cell_col_o (cell_col_o),
    .cell_row_o (cell_row_o),
    .last_o     (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long, none in the calm stretch
  function automatic int idle_gap();
    int pick;
    if (lines_sent >= 70 && lines_sent < 95) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one line request and wait for its beat
  task automatic send_line(input coord_t sc, input coord_t sr,
                           input coord_t ec, input coord_t er);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_col_i <= sc;
    start_row_i <= sr;
    end_col_i   <= ec;
    end_row_i   <= er;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    board.add_line(sc, sr, ec, er);
    lines_sent++;
  endtask

  // random line: half anywhere, some short, some pinned to the grid edges
  task automatic random_line();
    coord_t sc, sr, ec, er;
    int     kind;
    sc   = coord_t'($urandom_range(0, 31));
    sr   = coord_t'($urandom_range(0, 31));
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      ec = coord_t'($urandom_range(0, 31));
      er = coord_t'($urandom_range(0, 31));
    end else if (kind < 8) begin
      ec = coord_t'(int'(sc) + int'($urandom_range(0, 6)) - 3);
      er = coord_t'(int'(sr) + int'($urandom_range(0, 6)) - 3);
    end else begin
      sc = $urandom_range(0, 1) ? coord_t'(31) : coord_t'(0);
      ec = $urandom_range(0, 1) ? coord_t'(31) : coord_t'(0);
      er = coord_t'($urandom_range(0, 31));
    end
    send_line(sc, sr, ec, er);
  endtask

  // stimulus and end of run
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // same cell, even and odd columns
    send_line(5'd0, 5'd0, 5'd0, 5'd0);
    send_line(5'd31, 5'd31, 5'd31, 5'd31);
    send_line(5'd17, 5'd9, 5'd17, 5'd9);
    // corner to corner and along the edges
    send_line(5'd0, 5'd0, 5'd31, 5'd31);
    send_line(5'd31, 5'd31, 5'd0, 5'd0);
    send_line(5'd0, 5'd31, 5'd31, 5'd0);
    send_line(5'd31, 5'd0, 5'd0, 5'd31);
    send_line(5'd0, 5'd0, 5'd31, 5'd0);
    send_line(5'd0, 5'd0, 5'd0, 5'd31);
    send_line(5'd31, 5'd0, 5'd31, 5'd31);
    // neighbors across odd and even columns
    send_line(5'd1, 5'd0, 5'd2, 5'd0);
    send_line(5'd2, 5'd0, 5'd1, 5'd0);
    send_line(5'd3, 5'd5, 5'd3, 5'd6);
    // mostly even distances, where rounding ties land on the midpoints
    send_line(5'd0, 5'd0, 5'd4, 5'd1);
    send_line(5'd2, 5'd2, 5'd4, 5'd2);
    send_line(5'd5, 5'd5, 5'd7, 5'd4);
    send_line(5'd10, 5'd10, 5'd12, 5'd12);
    send_line(5'd1, 5'd1, 5'd3, 5'd0);
    send_line(5'd0, 5'd3, 5'd2, 5'd0);
    send_line(5'd6, 5'd1, 5'd0, 5'd4);
    repeat (RANDOM_LINES) random_line();
    in_valid_i <= 1'b0;
    while (board.cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver: check each cell beat, then pick the next ready
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        board.check_cell(cell_col_o, cell_row_o, last_o);
      end
      if (hold_off || stall_left > 0) begin
        out_ready_i <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // one long receiver hold so the job queue fills and input stalls
  initial begin
    do @(posedge clk_i); while (lines_sent < 40);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run timed out after %0d cycles", $time, cycle_count);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/hgl_pkg.sv
rtl/core/hgl_front.sv
rtl/core/hgl_queue.sv
rtl/core/hgl_back.sv
rtl/core/hex_grid_line_walker.sv
test/hex_grid_line_walker_tb.sv
